### hdl/spq_pkg.sv
// ----------------------------------------------------------------------------
// spq_pkg
// Shared constants, result codes and controller command type for the
// stable priority queue.
// ----------------------------------------------------------------------------
package spq_pkg;

  // default sizes
  localparam int QUEUE_DEPTH_DEF   = 16;
  localparam int PRIORITY_BITS_DEF = 8;
  localparam int HANDLE_BITS_DEF   = 16;

  // field widths on the ports
  localparam int OP_W        = 1;
  localparam int PRIO_FW     = 8;
  localparam int HANDLE_FW   = 16;
  localparam int STATUS_W    = 2;
  localparam int OCC_FW      = 5;
  localparam int IN_TDATA_W  = ((PRIO_FW + HANDLE_FW + 7) / 8) * 8;
  localparam int OUT_FIELD_W = PRIO_FW + HANDLE_FW + OCC_FW;
  localparam int OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;

  // operations
  localparam logic [OP_W-1:0] OP_INSERT = 1'b0;
  localparam logic [OP_W-1:0] OP_POP    = 1'b1;

  // result codes
  localparam logic [STATUS_W-1:0] RES_INSERTED = 2'd0;
  localparam logic [STATUS_W-1:0] RES_POPPED   = 2'd1;
  localparam logic [STATUS_W-1:0] RES_EMPTY    = 2'd2;
  localparam logic [STATUS_W-1:0] RES_FULL     = 2'd3;

  // controller to datapath
  typedef struct packed {
    logic load;   // capture the incoming request
    logic exec;   // apply it to the array and load the result register
  } spq_cmd_t;

endpackage

### hdl/stable_priority_queue.sv
// ----------------------------------------------------------------------------
// stable_priority_queue
// Bounded priority queue kept sorted in a shift-insert array; equal
// priorities leave in arrival order.
//
//   channel  direction  tuser            tdata
//   in_      request    operation        priority_req, message_handle
//   out_     result     status           out_priority, out_handle, occupancy
//
// Each request is first captured, then applied to the slot array while the
// result register is loaded, once that register is free. The array update
// is a single pass through the per-slot compare and select.
// A new request is taken while the previous result still waits on out_.
// Reset empties the queue; stored entries are not cleared.
// ----------------------------------------------------------------------------
module stable_priority_queue
  import spq_pkg::*;
#(
  parameter int QUEUE_DEPTH   = QUEUE_DEPTH_DEF,
  parameter int PRIORITY_BITS = PRIORITY_BITS_DEF,
  parameter int HANDLE_BITS   = HANDLE_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // priority_req, message_handle
  input  logic [OP_W-1:0]        in_tuser,   // operation
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // out_priority, out_handle, occupancy, pad
  output logic [STATUS_W-1:0]    out_tuser   // status
);

  spq_cmd_t             cmd;
  logic [STATUS_W-1:0]  res_status;
  logic [PRIO_FW-1:0]   res_prio;
  logic [HANDLE_FW-1:0] res_handle;
  logic [OCC_FW-1:0]    res_occ;

  spq_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .cmd        (cmd)
  );

  spq_dpath #(
    .QUEUE_DEPTH   (QUEUE_DEPTH),
    .PRIORITY_BITS (PRIORITY_BITS),
    .HANDLE_BITS   (HANDLE_BITS)
  ) u_dpath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .req_op     (in_tuser),
    .req_prio   (in_tdata[PRIO_FW-1:0]),
    .req_handle (in_tdata[PRIO_FW+HANDLE_FW-1:PRIO_FW]),
    .res_status (res_status),
    .res_prio   (res_prio),
    .res_handle (res_handle),
    .res_occ    (res_occ)
  );

  assign out_tuser = res_status;
  assign out_tdata = {{(OUT_TDATA_W - OUT_FIELD_W){1'b0}}, res_occ, res_handle, res_prio};

endmodule

### hdl/spq_ctrl.sv
// ----------------------------------------------------------------------------
// spq_ctrl
// Request sequencer: takes one request, runs it through the datapath
// once the result register is free, and tracks the result valid flag.
// ----------------------------------------------------------------------------
module spq_ctrl
  import spq_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_tvalid,
  output logic     in_tready,
  input  logic     out_tready,
  output logic     out_tvalid,
  output spq_cmd_t cmd
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EXEC = 1'b1;

  logic state_r, state_nxt;
  logic out_valid_r, out_valid_nxt;
  logic slot_free;

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign slot_free  = !out_valid_r || out_tready;

  always_comb begin
    cmd.load = 1'b0;
    cmd.exec = 1'b0;
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        // wait until the result register can take a new result
        if (slot_free) begin
          cmd.exec  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.exec) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

### hdl/spq_dpath.sv
// ----------------------------------------------------------------------------
// spq_dpath
// Sorted shift-insert array with request and result registers. Each slot
// compares its priority with the request and either holds, takes its
// neighbor or takes the new entry.
// ----------------------------------------------------------------------------
module spq_dpath
  import spq_pkg::*;
#(
  parameter int QUEUE_DEPTH   = QUEUE_DEPTH_DEF,
  parameter int PRIORITY_BITS = PRIORITY_BITS_DEF,
  parameter int HANDLE_BITS   = HANDLE_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  spq_cmd_t             cmd,
  input  logic [OP_W-1:0]      req_op,
  input  logic [PRIO_FW-1:0]   req_prio,
  input  logic [HANDLE_FW-1:0] req_handle,
  output logic [STATUS_W-1:0]  res_status,
  output logic [PRIO_FW-1:0]   res_prio,
  output logic [HANDLE_FW-1:0] res_handle,
  output logic [OCC_FW-1:0]    res_occ
);

  localparam int PW = PRIORITY_BITS;
  localparam int HW = HANDLE_BITS;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [CW-1:0] CNT_FULL = CW'(QUEUE_DEPTH);

  logic [PW-1:0] prio_r [QUEUE_DEPTH];
  logic [PW-1:0] prio_nxt [QUEUE_DEPTH];
  logic [HW-1:0] hdl_r [QUEUE_DEPTH];
  logic [HW-1:0] hdl_nxt [QUEUE_DEPTH];
  logic [CW-1:0] count_r, count_nxt;

  logic [OP_W-1:0] op_r;
  logic [PW-1:0]   new_prio_r;
  logic [HW-1:0]   new_hdl_r;

  logic [STATUS_W-1:0]  status_r, status_nxt;
  logic [PRIO_FW-1:0]   oprio_r, oprio_nxt;
  logic [HANDLE_FW-1:0] ohdl_r, ohdl_nxt;
  logic [OCC_FW-1:0]    occ_r;

  logic [QUEUE_DEPTH-1:0] lt;
  logic [QUEUE_DEPTH-1:0] lt_prev;
  logic [QUEUE_DEPTH-1:0] at_end;
  logic                   do_ins, do_pop;

  // width adapters between port fields and stored fields
  logic [PW+PRIO_FW-1:0]   prio_in_ext, prio_out_ext;
  logic [HW+HANDLE_FW-1:0] hdl_in_ext, hdl_out_ext;
  logic [CW+OCC_FW-1:0]    occ_ext;

  assign prio_in_ext  = {{PW{1'b0}}, req_prio};
  assign hdl_in_ext   = {{HW{1'b0}}, req_handle};
  assign prio_out_ext = {{PRIO_FW{1'b0}}, prio_r[0]};
  assign hdl_out_ext  = {{HANDLE_FW{1'b0}}, hdl_r[0]};
  assign occ_ext      = {{OCC_FW{1'b0}}, count_nxt};

  // slot i holds an entry of lower priority than the request
  always_comb begin
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      lt[i]     = (CW'(i) < count_r) && (prio_r[i] < new_prio_r);
      at_end[i] = (CW'(i) == count_r);
    end
    lt_prev = {lt[QUEUE_DEPTH-2:0], 1'b0};
  end

  assign do_ins = cmd.exec && (op_r == OP_INSERT) && (count_r != CNT_FULL);
  assign do_pop = cmd.exec && (op_r == OP_POP) && (count_r != '0);

  always_comb begin
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      prio_nxt[i] = prio_r[i];
      hdl_nxt[i]  = hdl_r[i];
    end
    count_nxt = count_r;
    if (do_ins) begin
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
        if (lt_prev[i]) begin
          // entries after the insertion point move down one slot
          prio_nxt[i] = (i == 0) ? prio_r[0] : prio_r[(i == 0) ? 0 : i - 1];
          hdl_nxt[i]  = (i == 0) ? hdl_r[0] : hdl_r[(i == 0) ? 0 : i - 1];
        end else if (lt[i] || at_end[i]) begin
          prio_nxt[i] = new_prio_r;
          hdl_nxt[i]  = new_hdl_r;
        end
      end
      count_nxt = count_r + CW'(1);
    end else if (do_pop) begin
      for (int i = 0; i < QUEUE_DEPTH - 1; i++) begin
        prio_nxt[i] = prio_r[i + 1];
        hdl_nxt[i]  = hdl_r[i + 1];
      end
      count_nxt = count_r - CW'(1);
    end
  end

  always_comb begin
    oprio_nxt = '0;
    ohdl_nxt  = '0;
    if (op_r == OP_INSERT) begin
      status_nxt = (count_r == CNT_FULL) ? RES_FULL : RES_INSERTED;
    end else if (count_r == '0) begin
      status_nxt = RES_EMPTY;
    end else begin
      status_nxt = RES_POPPED;
      oprio_nxt  = prio_out_ext[PRIO_FW-1:0];
      ohdl_nxt   = hdl_out_ext[HANDLE_FW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      prio_r[i] <= prio_nxt[i];
      hdl_r[i]  <= hdl_nxt[i];
    end
    if (cmd.load) begin
      op_r       <= req_op;
      new_prio_r <= prio_in_ext[PW-1:0];
      new_hdl_r  <= hdl_in_ext[HW-1:0];
    end
    if (cmd.exec) begin
      status_r <= status_nxt;
      oprio_r  <= oprio_nxt;
      ohdl_r   <= ohdl_nxt;
      occ_r    <= occ_ext[OCC_FW-1:0];
    end
  end

  assign res_status = status_r;
  assign res_prio   = oprio_r;
  assign res_handle = ohdl_r;
  assign res_occ    = occ_r;

endmodule

### verif/stable_priority_queue_tb.sv
// ----------------------------------------------------------------------------
// stable_priority_queue_tb
// Self-checking bench for the sorted priority queue. A local shadow of the
// slot array predicts status, popped entry and occupancy for every accepted
// request. Each result on out_ is checked in order against that prediction.
// Traffic runs through directed corner cases, random insert/pop bursts under
// several handshake idle patterns, and a long output hold-off that backs
// the block up into its input.
// ----------------------------------------------------------------------------
module stable_priority_queue_tb;
  import spq_pkg::*;

  localparam int DEPTH       = QUEUE_DEPTH_DEF;
  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 300;

  typedef struct {
    logic [STATUS_W-1:0]  status;
    logic [PRIO_FW-1:0]   prio;
    logic [HANDLE_FW-1:0] handle;
    logic [OCC_FW-1:0]    occupancy;
  } queue_result_t;

  logic                   clk        = 1'b0;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata   = '0;  // priority_req, message_handle
  logic [OP_W-1:0]        in_tuser   = OP_INSERT;  // operation
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;  // out_priority, out_handle, occupancy, pad
  logic [STATUS_W-1:0]    out_tuser;  // status

  // shadow of the sorted slot array
  logic [PRIO_FW-1:0]   slot_prio   [DEPTH];
  logic [HANDLE_FW-1:0] slot_handle [DEPTH];
  int                   slot_count = 0;

  queue_result_t pending_results[$];
  int            error_count  = 0;
  int            cycle_count  = 0;
  int            tx_idle_pct  = 0;
  int            rx_stall_pct = 0;
  bit            hold_start   = 1'b0;
  int            hold_left    = 0;

  stable_priority_queue uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("stable_priority_queue verification failed");
      $finish;
    end
  end

  // receiver: random stalls, plus a counted hold-off on request
  always @(posedge clk) begin
    if (hold_start) begin
      hold_left  = HOLD_CYCLES;
      hold_start = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  function automatic queue_result_t predict_queue_op(logic [OP_W-1:0] op,
                                                     logic [PRIO_FW-1:0] prio,
                                                     logic [HANDLE_FW-1:0] handle);
    queue_result_t r;
    int            pos;
    r.prio   = '0;
    r.handle = '0;
    if (op == OP_INSERT) begin
      if (slot_count >= DEPTH) begin
        r.status = RES_FULL;
      end else begin
        // new entry goes behind every entry of equal or higher priority
        pos = slot_count;
        for (int i = 0; i < slot_count; i++) begin
          if (pos == slot_count && slot_prio[i] < prio) pos = i;
        end
        for (int i = slot_count; i > pos; i--) begin
          slot_prio[i]   = slot_prio[i-1];
          slot_handle[i] = slot_handle[i-1];
        end
        slot_prio[pos]   = prio;
        slot_handle[pos] = handle;
        slot_count++;
        r.status = RES_INSERTED;
      end
    end else begin
      if (slot_count == 0) begin
        r.status = RES_EMPTY;
      end else begin
        r.prio   = slot_prio[0];
        r.handle = slot_handle[0];
        for (int i = 1; i < slot_count; i++) begin
          slot_prio[i-1]   = slot_prio[i];
          slot_handle[i-1] = slot_handle[i];
        end
        slot_count--;
        r.status = RES_POPPED;
      end
    end
    r.occupancy = OCC_FW'(slot_count);
    return r;
  endfunction

  task automatic send_request(logic [OP_W-1:0] op, logic [PRIO_FW-1:0] prio,
                              logic [HANDLE_FW-1:0] handle);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {handle, prio};
    do @(posedge clk); while (!in_tready);
    pending_results.push_back(predict_queue_op(op, prio, handle));
  endtask

  task automatic check_field(string name, int exp_val, int got_val);
    if (exp_val !== got_val) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_val, got_val);
      error_count++;
    end
  endtask

  always @(posedge clk) begin : result_check
    queue_result_t exp_res;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual status %0h data %0h",
                 $time, out_tuser, out_tdata);
        error_count++;
      end else begin
        exp_res = pending_results.pop_front();
        check_field("status", exp_res.status, out_tuser);
        check_field("priority", exp_res.prio, out_tdata[PRIO_FW-1:0]);
        check_field("handle", exp_res.handle, out_tdata[PRIO_FW +: HANDLE_FW]);
        check_field("occupancy", exp_res.occupancy,
                    out_tdata[PRIO_FW+HANDLE_FW +: OCC_FW]);
      end
    end
  end

  task automatic test_corner_cases();
    send_request(OP_POP, 8'h5a, 16'ha5a5);     // pop on empty queue
    send_request(OP_INSERT, 8'hff, 16'hffff);
    send_request(OP_INSERT, 8'h00, 16'h0000);
    send_request(OP_INSERT, 8'h80, 16'h000a);  // three equal priorities, fifo order
    send_request(OP_INSERT, 8'h80, 16'h000b);
    send_request(OP_INSERT, 8'h80, 16'h000c);
    send_request(OP_INSERT, 8'hff, 16'h0001);  // ties with head, lands behind it
    send_request(OP_POP, 8'h00, 16'h0000);
    send_request(OP_POP, 8'hff, 16'hffff);
  endtask

  task automatic test_full_queue();
    for (int i = 0; i < DEPTH - 3; i++) begin
      send_request(OP_INSERT, 8'(i * 37), 16'(16'h1000 + i));
    end
    send_request(OP_INSERT, 8'hff, 16'hdead);  // rejected, queue is full
    send_request(OP_POP, 8'h00, 16'h0000);
  endtask

  task automatic test_random_traffic(int n_items, int tx_pct, int rx_pct);
    int               insert_pct;
    logic [OP_W-1:0]  op;
    logic [PRIO_FW-1:0] prio;
    tx_idle_pct  = tx_pct;
    rx_stall_pct = rx_pct;
    insert_pct   = 25;
    for (int k = 0; k < n_items; k++) begin
      // alternate fill and drain bursts so both the full and empty edges get hit
      if (k % 32 == 0) insert_pct = (insert_pct == 75) ? 25 : 75;
      op   = ($urandom_range(99) < insert_pct) ? OP_INSERT : OP_POP;
      prio = $urandom_range(1) ? 8'($urandom_range(255)) : 8'(64 * $urandom_range(3));
      send_request(op, prio, 16'($urandom_range(16'hffff)));
    end
  endtask

  task automatic test_output_holdoff();
    tx_idle_pct  = 0;
    rx_stall_pct = 0;
    hold_start   = 1'b1;
    for (int k = 0; k < 40; k++) begin
      send_request($urandom_range(2) ? OP_INSERT : OP_POP, 8'($urandom_range(255)),
                   16'($urandom_range(16'hffff)));
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_corner_cases();
    test_full_queue();
    test_random_traffic(190, 0, 0);
    test_random_traffic(190, 80, 0);
    test_random_traffic(190, 0, 80);
    test_random_traffic(190, 26, 26);
    test_output_holdoff();
    in_tvalid    <= 1'b0;
    rx_stall_pct = 0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (error_count == 0) begin
      $display("stable_priority_queue verification clean");
    end else begin
      $display("stable_priority_queue verification failed");
    end
    $finish;
  end

endmodule

### files.f
hdl/spq_pkg.sv
hdl/spq_ctrl.sv
hdl/spq_dpath.sv
hdl/stable_priority_queue.sv
verif/stable_priority_queue_tb.sv
